// ----- rtl/u2u8_pkg.sv -----
// shared types, constants and utf-8 encode helpers for the utf-16 to utf-8 transcoder
// no dependencies
`default_nettype none

package u2u8_pkg;

    localparam int QDEPTH = 2;

    localparam logic [15:0] HI_FIRST = 16'hD800;
    localparam logic [15:0] HI_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_FIRST = 16'hDC00;
    localparam logic [15:0] LO_LAST  = 16'hDFFF;

    localparam logic [20:0] CP_REPL   = 21'h00FFFD;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] LIM1      = 21'h00007F;
    localparam logic [20:0] LIM2      = 21'h0007FF;
    localparam logic [20:0] LIM3      = 21'h00FFFF;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    typedef struct packed {
        logic        pre_repl;
        logic [2:0]  cp_len;
        logic [20:0] cp;
        logic        str_end;
    } t_job;

    function automatic logic [2:0] f_utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= LIM1) begin
            len = LEN_1;
        end else if (cp <= LIM2) begin
            len = LEN_2;
        end else if (cp <= LIM3) begin
            len = LEN_3;
        end else begin
            len = LEN_4;
        end
        return len;
    endfunction

    function automatic logic [7:0] f_utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                               input logic [1:0] j);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_1: b = cp[7:0];
            LEN_2: begin
                case (j)
                    2'd0:    b = LEAD2 | {3'b000, cp[10:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (j)
                    2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            LEN_4: begin
                case (j)
                    2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/u2u8_front.sv -----
// front end: accepts code units, tracks surrogate and discard state, builds encode jobs
// depends on u2u8_pkg
`default_nettype none

module u2u8_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [15:0]    i_code_unit,
    input  wire logic           i_last_unit,
    input  wire logic           i_q_full,
    output logic                o_push,
    output u2u8_pkg::t_job      o_job
);
    import u2u8_pkg::*;

    logic        r_high_pending, n_high_pending;
    logic [9:0]  r_high_bits, n_high_bits;
    logic        r_discarding, n_discarding;

    logic        w_accept;
    logic        w_is_hi;
    logic        w_is_lo;
    logic        w_enc;
    logic [20:0] w_cp;
    t_job        w_job;

    assign w_accept = i_valid && !i_q_full;
    assign w_is_hi  = (i_code_unit >= HI_FIRST) && (i_code_unit <= HI_LAST);
    assign w_is_lo  = (i_code_unit >= LO_FIRST) && (i_code_unit <= LO_LAST);

    always_comb begin
        n_high_pending = r_high_pending;
        n_high_bits    = r_high_bits;
        n_discarding   = r_discarding;
        w_enc          = 1'b0;
        w_cp           = CP_REPL;
        w_job          = '0;
        if (!r_discarding) begin
            n_high_pending = 1'b0;
            n_high_bits    = 10'd0;
            if (r_high_pending && w_is_lo) begin
                w_enc = 1'b1;
                w_cp  = SUPP_BASE + {1'b0, r_high_bits, i_code_unit[9:0]};
            end else begin
                w_job.pre_repl = r_high_pending;
                if (i_code_unit == 16'h0000) begin
                    n_discarding = 1'b1;
                end else if (w_is_hi) begin
                    if (i_last_unit) begin
                        w_enc = 1'b1;
                    end else begin
                        n_high_pending = 1'b1;
                        n_high_bits    = i_code_unit[9:0];
                    end
                end else if (w_is_lo) begin
                    w_enc = 1'b1;
                end else begin
                    w_enc = 1'b1;
                    w_cp  = {5'b00000, i_code_unit};
                end
            end
        end
        if (i_last_unit) begin
            n_high_pending = 1'b0;
            n_high_bits    = 10'd0;
            n_discarding   = 1'b0;
        end
        w_job.str_end = i_last_unit;
        w_job.cp      = w_cp;
        w_job.cp_len  = w_enc ? f_utf8_len(w_cp) : LEN_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pending <= 1'b0;
            r_high_bits    <= 10'd0;
            r_discarding   <= 1'b0;
        end else if (w_accept) begin
            r_high_pending <= n_high_pending;
            r_high_bits    <= n_high_bits;
            r_discarding   <= n_discarding;
        end
    end

    assign o_push = w_accept && (w_job.pre_repl || w_enc || i_last_unit);
    assign o_job  = w_job;

endmodule

`default_nettype wire

// ----- rtl/u2u8_queue.sv -----
// short job queue between the front and back ends
// depends on u2u8_pkg
`default_nettype none

module u2u8_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire u2u8_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output u2u8_pkg::t_job      o_job,
    output logic                o_empty
);
    import u2u8_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    t_job          r_mem [QDEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/u2u8_back.sv -----
// back end: walks a job one utf-8 byte per cycle into the output register while i_stall does not hold it
// depends on u2u8_pkg
`default_nettype none

module u2u8_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire u2u8_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [7:0]          o_utf8_byte,
    output logic                o_byte_valid,
    output logic                o_string_end
);
    import u2u8_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_byte_valid;
    logic       r_o_string_end;

    logic       w_adv;
    logic       w_load;
    logic [2:0] w_total;
    logic       w_last_byte;
    logic [2:0] w_j;
    logic [7:0] w_byte;
    logic       w_byte_valid;

    assign w_adv  = !r_o_valid || !i_stall;
    assign w_load = w_adv && i_head_valid;

    always_comb begin
        w_total = i_job.pre_repl ? (i_job.cp_len + 3'd3) : i_job.cp_len;
        if (w_total == 3'd0) begin
            w_total = 3'd1;
        end
        w_last_byte  = (r_idx == (w_total - 3'd1));
        w_byte_valid = i_job.pre_repl || (i_job.cp_len != LEN_NONE);
        w_j          = i_job.pre_repl ? (r_idx - 3'd3) : r_idx;
        if (!w_byte_valid) begin
            w_byte = 8'h00;
        end else if (i_job.pre_repl && (r_idx < 3'd3)) begin
            w_byte = f_utf8_byte(CP_REPL, LEN_3, r_idx[1:0]);
        end else begin
            w_byte = f_utf8_byte(i_job.cp, i_job.cp_len, w_j[1:0]);
        end
        n_idx = r_idx;
        if (w_load) begin
            n_idx = w_last_byte ? 3'd0 : (r_idx + 3'd1);
        end
    end

    assign o_pop = w_load && w_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= 3'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (w_adv) begin
                r_o_valid <= i_head_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_byte       <= w_byte;
            r_o_byte_valid <= w_byte_valid;
            r_o_string_end <= i_job.str_end && w_last_byte;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_utf8_byte  = r_o_byte;
    assign o_byte_valid = r_o_byte_valid;
    assign o_string_end = r_o_string_end;

    a_bare_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_byte_valid) |-> r_o_string_end)
        else $error("bare result without string end");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd5)
        else $error("byte index out of range");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_head_valid && (n_idx == 3'd0)))
        else $error("job popped while queue empty or mid-sequence");

endmodule

`default_nettype wire

// ----- rtl/utf16_to_utf8_transcoder_top.sv -----
// top level of the utf-16 to utf-8 transcoder: front end, job queue, back end
// depends on u2u8_pkg, u2u8_front, u2u8_queue, u2u8_back
//
// channel   dir  handshake          payload
// input     in   i_valid / o_stall  i_code_unit[15:0], i_last_unit
// result    out  o_valid / i_stall  o_utf8_byte[7:0], o_byte_valid, o_string_end
//
// the back end sends one byte per cycle from its output register while i_stall is low,
// and each unit yields its bytes: 1 to 3 for a plain unit, 4 for a surrogate pair,
// 3 to 6 when replacement characters come out, and 1 result for a bare end marker
// jobs pass the queue, then the output register; a two-job queue lets new units
// be taken while earlier bytes are still going out, and o_stall rises only when it is full
// reset is synchronous, active low, and clears surrogate, discard and queue state
// i_stall holds the output register; o_stall never depends on i_valid
`default_nettype none

module utf16_to_utf8_transcoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_last_unit,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_utf8_byte,
    output logic             o_byte_valid,
    output logic             o_string_end
);
    import u2u8_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_in_job;
    t_job w_head_job;

    u2u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_job       (w_in_job)
    );

    u2u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty)
    );

    u2u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!w_empty),
        .i_job        (w_head_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_utf8_byte  (o_utf8_byte),
        .o_byte_valid (o_byte_valid),
        .o_string_end (o_string_end)
    );

    assign o_stall = w_full;

endmodule

`default_nettype wire

// ----- tb/tb_utf16_to_utf8_transcoder_top.sv -----
// self-checking testbench for utf16_to_utf8_transcoder_top: directed and random utf-16 strings
// predicts the utf-8 byte stream in-bench; depends on u2u8_pkg and the transcoder rtl
`default_nettype none

module tb_utf16_to_utf8_transcoder_top;
    import u2u8_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_UNITS  = 160;
    localparam int TAIL_CYCLES   = 12;
    localparam int LONG_HOLD     = 80;
    localparam int EXP_DEPTH     = 256;
    localparam int MAX_STR       = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       is_byte;
        logic       is_end;
    } t_utf8_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_code_unit;
    logic        i_last_unit;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_utf8_byte;
    logic        o_byte_valid;
    logic        o_string_end;

    // expected bytes, ring of EXP_DEPTH entries
    t_utf8_out   exp_mem [EXP_DEPTH];
    logic [7:0]  exp_wr;
    logic [7:0]  exp_rd;

    // units of the random string being built
    logic [15:0] str_units [MAX_STR];
    int          str_len;

    // predictor state
    logic        hi_held;
    logic [9:0]  hi_bits;
    logic        dropping;
    int          step_bytes;

    int          err_count;
    int          units_sent;
    int          strings_sent;
    int          bytes_seen;
    int          cycle_count;
    int          hold_req;
    bit          gaps_on;

    utf16_to_utf8_transcoder_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_code_unit  (i_code_unit),
        .i_last_unit  (i_last_unit),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_utf8_byte  (o_utf8_byte),
        .o_byte_valid (o_byte_valid),
        .o_string_end (o_string_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic bit is_high(input logic [15:0] cu);
        return (cu >= HI_FIRST) && (cu <= HI_LAST);
    endfunction

    function automatic bit is_low(input logic [15:0] cu);
        return (cu >= LO_FIRST) && (cu <= LO_LAST);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        exp_mem[exp_wr] = '{data: b, is_byte: 1'b1, is_end: 1'b0};
        exp_wr = exp_wr + 8'd1;
        step_bytes++;
    endtask

    task automatic queue_codepoint(input logic [20:0] cp);
        if (cp <= LIM1) begin
            push_byte(cp[7:0]);
        end else if (cp <= LIM2) begin
            push_byte(LEAD2 | {3'b000, cp[10:6]});
            push_byte(CONT | {2'b00, cp[5:0]});
        end else if (cp <= LIM3) begin
            push_byte(LEAD3 | {4'b0000, cp[15:12]});
            push_byte(CONT | {2'b00, cp[11:6]});
            push_byte(CONT | {2'b00, cp[5:0]});
        end else begin
            push_byte(LEAD4 | {5'b00000, cp[20:18]});
            push_byte(CONT | {2'b00, cp[17:12]});
            push_byte(CONT | {2'b00, cp[11:6]});
            push_byte(CONT | {2'b00, cp[5:0]});
        end
    endtask

    task automatic fresh_unit(input logic [15:0] cu, input logic lu);
        if (cu == 16'h0000) begin
            dropping = 1'b1;
        end else if (is_high(cu)) begin
            if (lu) begin
                queue_codepoint(CP_REPL);
            end else begin
                hi_held = 1'b1;
                hi_bits = cu[9:0];
            end
        end else if (is_low(cu)) begin
            queue_codepoint(CP_REPL);
        end else begin
            queue_codepoint({5'b00000, cu});
        end
    endtask

    task automatic predict_unit(input logic [15:0] cu, input logic lu);
        step_bytes = 0;
        if (!dropping) begin
            if (hi_held && is_low(cu)) begin
                hi_held = 1'b0;
                queue_codepoint(SUPP_BASE + {1'b0, hi_bits, cu[9:0]});
                hi_bits = '0;
            end else if (hi_held) begin
                hi_held = 1'b0;
                hi_bits = '0;
                queue_codepoint(CP_REPL);
                fresh_unit(cu, lu);
            end else begin
                fresh_unit(cu, lu);
            end
        end
        if (lu) begin
            hi_held  = 1'b0;
            hi_bits  = '0;
            dropping = 1'b0;
            if (step_bytes == 0) begin
                exp_mem[exp_wr] = '{data: 8'h00, is_byte: 1'b0, is_end: 1'b1};
                exp_wr = exp_wr + 8'd1;
            end else begin
                exp_mem[exp_wr - 8'd1].is_end = 1'b1;
            end
            strings_sent++;
        end
    endtask

    task automatic send_unit(input logic [15:0] cu, input logic lu);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= cu;
        i_last_unit <= lu;
        do @(posedge i_clk); while (o_stall);
        predict_unit(cu, lu);
        units_sent++;
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (exp_wr != exp_rd);
    endtask

    task automatic add_unit(input logic [15:0] cu);
        str_units[str_len] = cu;
        str_len++;
    endtask

    // random unit of a mixed class; pairs come back as two units
    task automatic add_random_piece(input bit noise);
        int sel;
        sel = noise ? 99 : $urandom_range(0, 99);
        if (sel < 30) begin
            add_unit(16'($urandom_range(16'h0001, 16'h007F)));
        end else if (sel < 45) begin
            add_unit(16'($urandom_range(16'h0080, 16'h07FF)));
        end else if (sel < 65) begin
            if ($urandom_range(0, 1) == 1) begin
                add_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
            end else begin
                add_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
            end
        end else if (sel < 85) begin
            add_unit(16'($urandom_range(HI_FIRST, HI_LAST)));
            add_unit(16'($urandom_range(LO_FIRST, LO_LAST)));
        end else if (sel < 90) begin
            add_unit(16'($urandom_range(HI_FIRST, HI_LAST)));
        end else if (sel < 94) begin
            add_unit(16'($urandom_range(LO_FIRST, LO_LAST)));
        end else if (sel < 96) begin
            add_unit(16'h0000);
        end else begin
            add_unit(16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    task automatic send_random_string();
        int          pieces;
        bit          noise;
        noise   = ($urandom_range(0, 19) == 0);
        pieces  = $urandom_range(1, 6);
        str_len = 0;
        repeat (pieces) add_random_piece(noise);
        for (int k = 0; k < str_len; k++) begin
            send_unit(str_units[k], k == str_len - 1);
        end
    endtask

    // result side: random stalls, or one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (hold_req > 0) begin
                stall_left = hold_req - 1;
                hold_req   = 0;
                i_stall   <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_len() - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_utf8_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            bytes_seen++;
            if (exp_wr == exp_rd) begin
                err_count++;
                $display("%0t unexpected result: byte %02h valid %0b end %0b", $time,
                         o_utf8_byte, o_byte_valid, o_string_end);
            end else begin
                want   = exp_mem[exp_rd];
                exp_rd = exp_rd + 8'd1;
                if (o_utf8_byte !== want.data) begin
                    err_count++;
                    $display("%0t utf8_byte mismatch: expected %02h actual %02h", $time,
                             want.data, o_utf8_byte);
                end
                if (o_byte_valid !== want.is_byte) begin
                    err_count++;
                    $display("%0t byte_valid mismatch: expected %0b actual %0b", $time,
                             want.is_byte, o_byte_valid);
                end
                if (o_string_end !== want.is_end) begin
                    err_count++;
                    $display("%0t string_end mismatch: expected %0b actual %0b", $time,
                             want.is_end, o_string_end);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic test_bmp_extremes();
        send_unit(16'h0001, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        wait_drain();
    endtask

    task automatic test_surrogate_pairs();
        send_unit(HI_FIRST, 1'b0);
        send_unit(LO_FIRST, 1'b0);
        send_unit(HI_LAST, 1'b0);
        send_unit(LO_LAST, 1'b1);
        wait_drain();
    endtask

    task automatic test_lone_surrogates();
        // held high then plain, held high then high, a pair, stray low, high as final unit
        send_unit(HI_FIRST, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hD9AB, 1'b0);
        send_unit(HI_LAST, 1'b0);
        send_unit(LO_LAST, 1'b0);
        send_unit(LO_FIRST, 1'b0);
        send_unit(HI_LAST, 1'b1);
        wait_drain();
    endtask

    task automatic test_zero_terminator();
        // zero ends the string, rest dropped, bare marker on a dropped last unit
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h0042, 1'b0);
        send_unit(LO_FIRST, 1'b1);
        send_unit(HI_FIRST, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        send_unit(16'h0000, 1'b1);
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        gaps_on  = 1'b0;
        hold_req = LONG_HOLD;
        repeat (12) send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), 1'b0);
        send_unit(16'h0024, 1'b1);
        wait_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (6) send_random_string();
        wait_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_strings();
        int stop_at;
        stop_at = units_sent + RANDOM_UNITS;
        while (units_sent < stop_at) begin
            send_random_string();
            if ($urandom_range(0, 7) == 0) begin
                wait_drain();
            end
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_code_unit  = '0;
        i_last_unit  = 1'b0;
        exp_wr       = '0;
        exp_rd       = '0;
        str_len      = 0;
        hi_held      = 1'b0;
        hi_bits      = '0;
        dropping     = 1'b0;
        step_bytes   = 0;
        err_count    = 0;
        units_sent   = 0;
        strings_sent = 0;
        bytes_seen   = 0;
        hold_req     = 0;
        gaps_on      = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bmp_extremes();
        test_surrogate_pairs();
        test_lone_surrogates();
        test_zero_terminator();
        test_output_backpressure();
        test_back_to_back();
        test_random_strings();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d code units in %0d strings, checked %0d output bytes", units_sent,
                 strings_sent, bytes_seen);
        $display("covered pairs, lone surrogates, terminators, long output hold, %0d errors",
                 err_count);
        if (err_count == 0 && exp_wr == exp_rd) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
